/* rtl/lidar_assisted_teleop_guard_assert.svh */
// assertion macros shared by the guard rtl
`ifndef LIDAR_ASSISTED_TELEOP_GUARD_ASSERT_SVH
`define LIDAR_ASSISTED_TELEOP_GUARD_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LATG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latg: same-cycle check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define LATG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latg: next-cycle check failed");

`endif

/* rtl/latg_pkg.sv */
// shared types, constants and key table of the teleop guard
`default_nettype none

package latg_pkg;

    localparam int SECTORS     = 5;
    localparam int SEC_W       = $clog2(SECTORS);
    localparam int CFG_W       = 16;
    localparam int SPEED_W     = 24;
    localparam int VEL_W       = 25;
    localparam int SCALED_W    = 28;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [CFG_W-1:0]   OBSTACLE_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0]   FAR_START_RESET = 16'd50000;
    localparam logic [SPEED_W-1:0] LIN_SPEED_RESET = 24'd32768;
    localparam logic [SPEED_W-1:0] TURN_RATE_RESET = 24'd65536;
    localparam logic [SPEED_W-1:0] SPEED_MAX       = 24'hFFFFFF;
    // ceil(2^32 / 10): exact floor division by ten for 28-bit numerators
    localparam logic [RECIP_W-1:0] RECIP_10        = 29'd429496730;
    localparam logic [7:0]         KEY_CTRL_C      = 8'h03;

    localparam logic REQ_KEY   = 1'b0;
    localparam logic REQ_RANGE = 1'b1;

    localparam logic CFG_OBSTACLE  = 1'b0;
    localparam logic CFG_FAR_START = 1'b1;

    // sector order follows scan angle
    localparam int SEC_RIGHT       = 0;
    localparam int SEC_FRONT_RIGHT = 1;
    localparam int SEC_FRONT       = 2;
    localparam int SEC_FRONT_LEFT  = 3;
    localparam int SEC_LEFT        = 4;

    typedef logic signed [1:0] dir_t;

    localparam dir_t D_POS  = 2'sb01;
    localparam dir_t D_NEG  = 2'sb11;
    localparam dir_t D_ZERO = 2'sb00;

    typedef enum logic [1:0] {
        ACT_USER  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_LEFT  = 2'd2,
        ACT_RIGHT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    typedef struct packed {
        dir_t x;
        dir_t y;
        dir_t z;
        dir_t yaw;
    } dir4_t;

    typedef struct packed {
        logic  move_hit;
        dir4_t dir;
        logic  speed_hit;
        step_t lin_step;
        step_t ang_step;
    } key_decode_t;

    typedef struct packed {
        dir4_t              dir;
        logic [SPEED_W-1:0] lin_speed;
        logic [SPEED_W-1:0] turn_rate;
        logic               exit_req;
    } motion_t;

    typedef struct packed {
        logic               scan_done;
        logic [SECTORS-1:0] blocked;
    } scan_status_t;

    function automatic key_decode_t decode_key(input logic [7:0] key);
        key_decode_t kd;
        kd = '0;
        kd.move_hit  = 1'b1;
        kd.lin_step  = STEP_HOLD;
        kd.ang_step  = STEP_HOLD;
        case (key)
            "i":     kd.dir = {D_POS,  D_ZERO, D_ZERO, D_ZERO};
            "o":     kd.dir = {D_POS,  D_ZERO, D_ZERO, D_NEG};
            "j":     kd.dir = {D_ZERO, D_ZERO, D_ZERO, D_POS};
            "l":     kd.dir = {D_ZERO, D_ZERO, D_ZERO, D_NEG};
            "u":     kd.dir = {D_POS,  D_ZERO, D_ZERO, D_POS};
            ",":     kd.dir = {D_NEG,  D_ZERO, D_ZERO, D_ZERO};
            ".":     kd.dir = {D_NEG,  D_ZERO, D_ZERO, D_POS};
            "m":     kd.dir = {D_NEG,  D_ZERO, D_ZERO, D_NEG};
            "O":     kd.dir = {D_POS,  D_NEG,  D_ZERO, D_ZERO};
            "I":     kd.dir = {D_POS,  D_ZERO, D_ZERO, D_ZERO};
            "J":     kd.dir = {D_ZERO, D_POS,  D_ZERO, D_ZERO};
            "L":     kd.dir = {D_ZERO, D_NEG,  D_ZERO, D_ZERO};
            "U":     kd.dir = {D_POS,  D_POS,  D_ZERO, D_ZERO};
            "<":     kd.dir = {D_NEG,  D_ZERO, D_ZERO, D_ZERO};
            ">":     kd.dir = {D_NEG,  D_NEG,  D_ZERO, D_ZERO};
            "M":     kd.dir = {D_NEG,  D_POS,  D_ZERO, D_ZERO};
            "t":     kd.dir = {D_ZERO, D_ZERO, D_POS,  D_ZERO};
            "b":     kd.dir = {D_ZERO, D_ZERO, D_NEG,  D_ZERO};
            "k":     kd.dir = {D_ZERO, D_ZERO, D_ZERO, D_ZERO};
            "K":     kd.dir = {D_ZERO, D_ZERO, D_ZERO, D_ZERO};
            "q":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.lin_step = STEP_UP; kd.ang_step = STEP_UP;
            end
            "z":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.lin_step = STEP_DOWN; kd.ang_step = STEP_DOWN;
            end
            "w":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.lin_step = STEP_UP;
            end
            "x":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.lin_step = STEP_DOWN;
            end
            "e":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.ang_step = STEP_UP;
            end
            "c":
            begin
                kd.move_hit = 1'b0; kd.speed_hit = 1'b1;
                kd.ang_step = STEP_DOWN;
            end
            default: kd.move_hit = 1'b0;
        endcase
        return kd;
    endfunction

endpackage

`default_nettype wire

/* rtl/latg_key.sv */
// key decoder with direction and speed state
`default_nettype none

module latg_key (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_go,
    input  logic [7:0]        key_code,
    output latg_pkg::motion_t motion
);

    `include "lidar_assisted_teleop_guard_assert.svh"

    latg_pkg::dir4_t                     dir_reg;
    latg_pkg::dir4_t                     dir_next;
    logic [latg_pkg::SPEED_W-1:0]        lin_speed_reg;
    logic [latg_pkg::SPEED_W-1:0]        lin_speed_next;
    logic [latg_pkg::SPEED_W-1:0]        turn_rate_reg;
    logic [latg_pkg::SPEED_W-1:0]        turn_rate_next;
    logic                                exit_req;
    latg_pkg::key_decode_t               kd;

    // round(v * 1.1) or round(v * 0.9), halves up; up saturates
    function automatic logic [latg_pkg::SPEED_W-1:0] scale_speed(
        input logic [latg_pkg::SPEED_W-1:0] v,
        input latg_pkg::step_t              step
    );
        logic [latg_pkg::SCALED_W-1:0] num;
        logic [latg_pkg::PROD_W-1:0]   prod;
        logic [latg_pkg::QUO_W-1:0]    quo;
        if (step == latg_pkg::STEP_UP)
        begin
            num = {4'd0, v} + {3'd0, v, 1'b0} + {1'd0, v, 3'b0}
                + latg_pkg::SCALED_W'(5);
        end
        else
        begin
            num = {4'd0, v} + {1'd0, v, 3'b0} + latg_pkg::SCALED_W'(5);
        end
        prod = latg_pkg::PROD_W'(num) * latg_pkg::PROD_W'(latg_pkg::RECIP_10);
        quo  = prod[latg_pkg::PROD_W-1:latg_pkg::RECIP_SHIFT];
        if (step == latg_pkg::STEP_HOLD)
            return v;
        else if (quo[latg_pkg::QUO_W-1:latg_pkg::SPEED_W] != '0)
            return latg_pkg::SPEED_MAX;
        else
            return quo[latg_pkg::SPEED_W-1:0];
    endfunction

    always_comb
    begin
        kd             = latg_pkg::decode_key(key_code);
        dir_next       = dir_reg;
        lin_speed_next = lin_speed_reg;
        turn_rate_next = turn_rate_reg;
        exit_req       = 1'b0;
        if (key_go)
        begin
            if (kd.move_hit)
            begin
                dir_next = kd.dir;
            end
            else if (kd.speed_hit)
            begin
                lin_speed_next = scale_speed(lin_speed_reg, kd.lin_step);
                turn_rate_next = scale_speed(turn_rate_reg, kd.ang_step);
            end
            else
            begin
                dir_next = '0;
                exit_req = (key_code == latg_pkg::KEY_CTRL_C);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= '0;
            lin_speed_reg <= latg_pkg::LIN_SPEED_RESET;
            turn_rate_reg <= latg_pkg::TURN_RATE_RESET;
        end
        else
        begin
            dir_reg       <= dir_next;
            lin_speed_reg <= lin_speed_next;
            turn_rate_reg <= turn_rate_next;
        end
    end

    // updated state feeds the command of this beat
    assign motion.dir       = dir_next;
    assign motion.lin_speed = lin_speed_next;
    assign motion.turn_rate = turn_rate_next;
    assign motion.exit_req  = exit_req;

    // rounding keeps both speeds off zero
    `LATG_ASSERT_IMP(a_speed_nonzero, 1'b1, lin_speed_reg != '0 && turn_rate_reg != '0)

endmodule

`default_nettype wire

/* rtl/latg_scan.sv */
// sector minimum tracker over one range scan
`default_nettype none

module latg_scan #(
    parameter int SAMPLES_PER_SCAN = 720,
    parameter int RANGE_BITS       = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       scan_go,
    input  logic [RANGE_BITS-1:0]      range_mm,
    input  logic [latg_pkg::CFG_W-1:0] obstacle_mm,
    input  logic [latg_pkg::CFG_W-1:0] far_start_mm,
    output latg_pkg::scan_status_t     status
);

    `include "lidar_assisted_teleop_guard_assert.svh"

    localparam int IDX_W = $clog2(SAMPLES_PER_SCAN);
    localparam int ACC_W = $clog2(SAMPLES_PER_SCAN + latg_pkg::SECTORS);
    localparam int MIN_W = (RANGE_BITS > latg_pkg::CFG_W) ? RANGE_BITS : latg_pkg::CFG_W;
    localparam int SEC_W = latg_pkg::SEC_W;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] acc_sum;
    logic [SEC_W-1:0] sec_reg;
    logic [SEC_W-1:0] sec_next;
    logic [MIN_W-1:0] min_reg  [latg_pkg::SECTORS];
    logic [MIN_W-1:0] min_next [latg_pkg::SECTORS];
    logic [MIN_W-1:0] base;
    logic [MIN_W-1:0] range_w;
    logic [latg_pkg::SECTORS-1:0] blocked;
    logic             first;
    logic             last;

    assign range_w = MIN_W'(range_mm);
    assign first   = (idx_reg == '0);
    assign last    = (idx_reg == IDX_W'(SAMPLES_PER_SCAN - 1));
    assign acc_sum = acc_reg + ACC_W'(latg_pkg::SECTORS);

    // running minima, reloaded at the first sample of a scan
    always_comb
    begin
        for (int i = 0; i < latg_pkg::SECTORS; i++)
        begin
            base        = first ? MIN_W'(far_start_mm) : min_reg[i];
            min_next[i] = min_reg[i];
            if (scan_go)
            begin
                min_next[i] = base;
                if (sec_reg == SEC_W'(i) && range_w <= base)
                    min_next[i] = range_w;
            end
            blocked[i] = min_next[i] < MIN_W'(obstacle_mm);
        end
    end

    // sector = index * sectors / samples, kept as quotient and remainder
    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        sec_next = sec_reg;
        if (scan_go)
        begin
            if (last)
            begin
                idx_next = '0;
                acc_next = '0;
                sec_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (acc_sum >= ACC_W'(SAMPLES_PER_SCAN))
                begin
                    acc_next = acc_sum - ACC_W'(SAMPLES_PER_SCAN);
                    sec_next = sec_reg + SEC_W'(1);
                end
                else
                begin
                    acc_next = acc_sum;
                end
            end
        end
    end

    assign status.blocked   = blocked;
    assign status.scan_done = scan_go && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
            sec_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            sec_reg <= sec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < latg_pkg::SECTORS; i++)
            min_reg[i] <= min_next[i];
    end

    `LATG_ASSERT_IMP(a_sector_range, 1'b1, sec_reg <= SEC_W'(latg_pkg::SECTORS - 1) && acc_reg < ACC_W'(SAMPLES_PER_SCAN))
    `LATG_ASSERT_IMP(a_last_in_left, last, sec_reg == SEC_W'(latg_pkg::SECTORS - 1))

endmodule

`default_nettype wire

/* rtl/lidar_assisted_teleop_guard.sv */
// top level of the range-guarded keyboard teleop block
`default_nettype none

// Keyboard teleop guard. Every beat on the input channel is either a key
// event or one range sample of a scan. A key event always yields one
// velocity command (lin_x, lin_y, lin_z, ang_z in signed Q8.16) built from
// the updated direction and speeds; ctrl-c zeroes the direction and flags
// mode_exit. Range samples arrive in angle order, SAMPLES_PER_SCAN per scan,
// split into five equal sectors (right, front-right, front, front-left,
// left); only the last sample of a scan yields a command, overridden to
// stop, turn left or turn right when the front or a side pair of sectors
// reads closer than obstacle_mm. Throughput is one beat per clock while the
// result channel does not stall; a beat goes from the input register through
// one pass of the key decoder and speed scaler or the sector minimum update
// into the result register. The speed and sector state loops close within
// that one pass, which is what sets the one-beat-per-clock figure. Config
// writes are always ready and should only be made while the block is idle.
module lidar_assisted_teleop_guard #(
    parameter int SAMPLES_PER_SCAN = 720,
    parameter int RANGE_BITS       = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [latg_pkg::CFG_W-1:0]        cfg_data,
    // input beats
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [7:0]                        key_code,
    input  logic [RANGE_BITS-1:0]             range_mm,
    // result beats
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [latg_pkg::VEL_W-1:0] lin_x,
    output logic signed [latg_pkg::VEL_W-1:0] lin_y,
    output logic signed [latg_pkg::VEL_W-1:0] lin_z,
    output logic signed [latg_pkg::VEL_W-1:0] ang_z,
    output logic [1:0]                        avoid_action,
    output logic                              mode_exit
);

    `include "lidar_assisted_teleop_guard_assert.svh"

    localparam int VEL_W = latg_pkg::VEL_W;

    // configuration registers
    logic [latg_pkg::CFG_W-1:0] obstacle_reg;
    logic [latg_pkg::CFG_W-1:0] far_start_reg;

    // input register
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_type_reg;
    logic [7:0]            s1_key_reg;
    logic [RANGE_BITS-1:0] s1_range_reg;
    logic                  s1_go;
    logic                  in_accept;
    logic                  key_go;
    logic                  scan_go;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [VEL_W-1:0]  lin_x_reg;
    logic signed [VEL_W-1:0]  lin_y_reg;
    logic signed [VEL_W-1:0]  lin_z_reg;
    logic signed [VEL_W-1:0]  ang_z_reg;
    latg_pkg::action_t        act_reg;
    logic                     mode_exit_reg;

    // command building
    latg_pkg::motion_t        motion;
    latg_pkg::scan_status_t   status;
    logic                     res_valid;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic signed [VEL_W-1:0]  vz;
    logic signed [VEL_W-1:0]  vyaw;
    logic signed [VEL_W-1:0]  tr_pos;
    logic signed [VEL_W-1:0]  res_x;
    logic signed [VEL_W-1:0]  res_yaw;
    logic signed [VEL_W-1:0]  res_y;
    latg_pkg::action_t        res_act;
    logic                     res_exit;

    // signed direction times magnitude: direction is only -1, 0 or +1
    function automatic logic signed [VEL_W-1:0] apply_dir(
        input latg_pkg::dir_t               d,
        input logic [latg_pkg::SPEED_W-1:0] mag
    );
        logic signed [VEL_W-1:0] m;
        m = signed'({1'b0, mag});
        case (d)
            latg_pkg::D_POS: return m;
            latg_pkg::D_NEG: return -m;
            default:         return '0;
        endcase
    endfunction

    // config port never back-pressures
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg  <= latg_pkg::OBSTACLE_RESET;
            far_start_reg <= latg_pkg::FAR_START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                latg_pkg::CFG_OBSTACLE:  obstacle_reg  <= cfg_data;
                latg_pkg::CFG_FAR_START: far_start_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // the held beat moves on whenever the result slot is free or draining;
    // a range beat with no result still waits for that, which costs nothing
    // in steady state and keeps the handshake simple
    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign key_go    = s1_go && (s1_type_reg == latg_pkg::REQ_KEY);
    assign scan_go   = s1_go && (s1_type_reg == latg_pkg::REQ_RANGE);

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_type_reg  <= req_type;
            s1_key_reg   <= key_code;
            s1_range_reg <= range_mm;
        end
    end

    latg_key u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_go   (key_go),
        .key_code (s1_key_reg),
        .motion   (motion)
    );

    latg_scan #(
        .SAMPLES_PER_SCAN (SAMPLES_PER_SCAN),
        .RANGE_BITS       (RANGE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_go      (scan_go),
        .range_mm     (s1_range_reg),
        .obstacle_mm  (obstacle_reg),
        .far_start_mm (far_start_reg),
        .status       (status)
    );

    // user command from the current direction and speeds
    assign vx     = apply_dir(motion.dir.x,   motion.lin_speed);
    assign vy     = apply_dir(motion.dir.y,   motion.lin_speed);
    assign vz     = apply_dir(motion.dir.z,   motion.lin_speed);
    assign vyaw   = apply_dir(motion.dir.yaw, motion.turn_rate);
    assign tr_pos = signed'({1'b0, motion.turn_rate});

    assign res_valid = key_go || status.scan_done;

    // guard priority: front blocked, then right pair, then left pair
    always_comb
    begin
        res_x    = vx;
        res_y    = vy;
        res_yaw  = vyaw;
        res_act  = latg_pkg::ACT_USER;
        res_exit = 1'b0;
        if (key_go)
        begin
            res_exit = motion.exit_req;
        end
        else if (status.blocked[latg_pkg::SEC_FRONT])
        begin
            // vertical motion is left alone on a stop
            res_x   = '0;
            res_y   = '0;
            res_yaw = '0;
            res_act = latg_pkg::ACT_STOP;
        end
        else if (status.blocked[latg_pkg::SEC_FRONT_RIGHT]
                 && status.blocked[latg_pkg::SEC_RIGHT])
        begin
            res_yaw = tr_pos;
            res_act = latg_pkg::ACT_LEFT;
        end
        else if (status.blocked[latg_pkg::SEC_FRONT_LEFT]
                 && status.blocked[latg_pkg::SEC_LEFT])
        begin
            res_yaw = -tr_pos;
            res_act = latg_pkg::ACT_RIGHT;
        end
    end

    always_comb
    begin
        if (res_valid)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload, loaded only when a new beat is produced
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            lin_x_reg     <= res_x;
            lin_y_reg     <= res_y;
            lin_z_reg     <= vz;
            ang_z_reg     <= res_yaw;
            act_reg       <= res_act;
            mode_exit_reg <= res_exit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lin_x        = lin_x_reg;
    assign lin_y        = lin_y_reg;
    assign lin_z        = lin_z_reg;
    assign ang_z        = ang_z_reg;
    assign avoid_action = act_reg;
    assign mode_exit    = mode_exit_reg;

    // a held beat is not dropped while the result slot is stuck
    `LATG_ASSERT_NEXT(a_item_held, s1_valid_reg && out_valid_reg && out_stall, s1_valid_reg)
    // an exit command is a plain zero-velocity user command
    `LATG_ASSERT_IMP(a_exit_zero, out_valid_reg && mode_exit_reg, act_reg == latg_pkg::ACT_USER && lin_x_reg == '0 && lin_y_reg == '0 && ang_z_reg == '0)
    // a stop keeps forward and yaw at rest
    `LATG_ASSERT_IMP(a_stop_still, out_valid_reg && act_reg == latg_pkg::ACT_STOP, lin_x_reg == '0 && ang_z_reg == '0 && !mode_exit_reg)

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking testbench for the range-guarded keyboard teleop block
`timescale 1ns / 100ps

module testbench;

    // scan length used by the block under test and by the prediction
    localparam int SCAN_LEN       = 720;
    localparam int RNG_W          = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SPEED_KEY_BASE = 20;

    // one input beat as queued for the driver
    typedef struct packed {
        logic             req;
        logic [7:0]       key;
        logic [RNG_W-1:0] rng;
    } input_beat_t;

    // one velocity command as seen on the result channel
    typedef struct packed {
        logic signed [latg_pkg::VEL_W-1:0] lx;
        logic signed [latg_pkg::VEL_W-1:0] ly;
        logic signed [latg_pkg::VEL_W-1:0] lz;
        logic signed [latg_pkg::VEL_W-1:0] az;
        latg_pkg::action_t                 act;
        logic                              ex;
    } vel_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index = latg_pkg::CFG_OBSTACLE;
    logic [latg_pkg::CFG_W-1:0] cfg_data = '0;

    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             req_type = latg_pkg::REQ_KEY;
    logic [7:0]       key_code = '0;
    logic [RNG_W-1:0] range_mm = '0;

    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [latg_pkg::VEL_W-1:0] lin_x;
    logic signed [latg_pkg::VEL_W-1:0] lin_y;
    logic signed [latg_pkg::VEL_W-1:0] lin_z;
    logic signed [latg_pkg::VEL_W-1:0] ang_z;
    logic [1:0]                        avoid_action;
    logic                              mode_exit;

    // beats waiting for the driver, and commands still owed by the block
    input_beat_t input_beats[$];
    vel_cmd_t    pending_cmds[$];

    // predicted state of the guard
    logic [latg_pkg::CFG_W-1:0]   obst_cfg = latg_pkg::OBSTACLE_RESET;
    logic [latg_pkg::CFG_W-1:0]   far_cfg  = latg_pkg::FAR_START_RESET;
    latg_pkg::dir4_t              heading  = '0;
    logic [latg_pkg::SPEED_W-1:0] lin_spd  = latg_pkg::LIN_SPEED_RESET;
    logic [latg_pkg::SPEED_W-1:0] turn_spd = latg_pkg::TURN_RATE_RESET;
    logic [latg_pkg::CFG_W-1:0]   sec_min[latg_pkg::SECTORS];
    logic [9:0]                   scan_idx = '0;

    // stimulus bookkeeping
    string       known_keys = "ijlou,.mOIJLU<>MtbkKqzwxec";
    int          gen_pos = 0;
    logic [latg_pkg::SECTORS-1:0] near_mask = '0;

    // handshake and idling state
    bit          in_taken = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;
    bit          tail_quiet = 1'b0;
    int          stretch_left = 0;
    int          cycles = 0;
    int          faults = 0;
    input_beat_t next_beat;
    vel_cmd_t    got_cmd;
    vel_cmd_t    want_cmd;

    lidar_assisted_teleop_guard #(
        .SAMPLES_PER_SCAN (SCAN_LEN),
        .RANGE_BITS       (RNG_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .key_code     (key_code),
        .range_mm     (range_mm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lin_x        (lin_x),
        .lin_y        (lin_y),
        .lin_z        (lin_z),
        .ang_z        (ang_z),
        .avoid_action (avoid_action),
        .mode_exit    (mode_exit)
    );

    initial
    begin
        foreach (sec_min[i])
            sec_min[i] = latg_pkg::FAR_START_RESET;
        forever
            #5 clk = ~clk;
    end

    // movement keys: each axis is set from its own key group, everything else zero
    function automatic bit move_for_key(input logic [7:0] k, output latg_pkg::dir4_t d);
        d = '0;
        case (k)
            "i", "o", "u", "O", "I", "U": d.x = latg_pkg::D_POS;
            ",", ".", "m", "<", ">", "M": d.x = latg_pkg::D_NEG;
            default: ;
        endcase
        case (k)
            "J", "U", "M": d.y = latg_pkg::D_POS;
            "O", "L", ">": d.y = latg_pkg::D_NEG;
            default: ;
        endcase
        case (k)
            "t": d.z = latg_pkg::D_POS;
            "b": d.z = latg_pkg::D_NEG;
            default: ;
        endcase
        case (k)
            "j", "u", ".": d.yaw = latg_pkg::D_POS;
            "o", "l", "m": d.yaw = latg_pkg::D_NEG;
            default: ;
        endcase
        case (k)
            "i", "o", "j", "l", "u", ",", ".", "m", "O", "I",
            "J", "L", "U", "<", ">", "M", "t", "b", "k", "K": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // speed keys: which of linear speed and turn rate go up or down
    function automatic bit speed_for_key(input logic [7:0] k, output latg_pkg::step_t ls,
                                         output latg_pkg::step_t as);
        ls = latg_pkg::STEP_HOLD;
        as = latg_pkg::STEP_HOLD;
        case (k)
            "q": begin ls = latg_pkg::STEP_UP;   as = latg_pkg::STEP_UP;   end
            "z": begin ls = latg_pkg::STEP_DOWN; as = latg_pkg::STEP_DOWN; end
            "w": ls = latg_pkg::STEP_UP;
            "x": ls = latg_pkg::STEP_DOWN;
            "e": as = latg_pkg::STEP_UP;
            "c": as = latg_pkg::STEP_DOWN;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // x1.1 or x0.9 with halves rounded up, upward steps saturating
    function automatic logic [latg_pkg::SPEED_W-1:0] rescale(
        input logic [latg_pkg::SPEED_W-1:0] v,
        input latg_pkg::step_t              s
    );
        logic [31:0] t;
        t = 32'(v);
        case (s)
            latg_pkg::STEP_UP:
            begin
                t = (t * 32'd11 + 32'd5) / 32'd10;
                if (t > 32'(latg_pkg::SPEED_MAX))
                    t = 32'(latg_pkg::SPEED_MAX);
            end
            latg_pkg::STEP_DOWN: t = (t * 32'd9 + 32'd5) / 32'd10;
            default: ;
        endcase
        return t[latg_pkg::SPEED_W-1:0];
    endfunction

    function automatic logic signed [latg_pkg::VEL_W-1:0] vel(
        input latg_pkg::dir_t               d,
        input logic [latg_pkg::SPEED_W-1:0] s
    );
        case (d)
            latg_pkg::D_POS: return $signed({1'b0, s});
            latg_pkg::D_NEG: return -$signed({1'b0, s});
            default: return '0;
        endcase
    endfunction

    // advance the predicted guard by one accepted beat, queueing any command it owes
    task automatic guard_step(input logic req, input logic [7:0] k,
                              input logic [RNG_W-1:0] rng);
        latg_pkg::dir4_t              d;
        latg_pkg::step_t              ls;
        latg_pkg::step_t              as;
        int                           sec;
        logic [latg_pkg::SECTORS-1:0] near;
        vel_cmd_t                     c;
        c = '0;
        c.act = latg_pkg::ACT_USER;
        if (req == latg_pkg::REQ_KEY)
        begin
            if (move_for_key(k, d))
                heading = d;
            else if (speed_for_key(k, ls, as))
            begin
                lin_spd  = rescale(lin_spd, ls);
                turn_spd = rescale(turn_spd, as);
            end
            else
            begin
                // unknown key stops; ctrl-c also asks to leave teleop
                heading = '0;
                c.ex = (k == latg_pkg::KEY_CTRL_C);
            end
            c.lx = vel(heading.x, lin_spd);
            c.ly = vel(heading.y, lin_spd);
            c.lz = vel(heading.z, lin_spd);
            c.az = vel(heading.yaw, turn_spd);
            pending_cmds.push_back(c);
        end
        else
        begin
            if (scan_idx == 0)
                foreach (sec_min[i])
                    sec_min[i] = far_cfg;
            sec = scan_idx * latg_pkg::SECTORS / SCAN_LEN;
            if (rng <= sec_min[sec])
                sec_min[sec] = rng;
            if (scan_idx + 1 < SCAN_LEN)
                scan_idx = scan_idx + 10'd1;
            else
            begin
                scan_idx = '0;
                for (int i = 0; i < latg_pkg::SECTORS; i++)
                    near[i] = sec_min[i] < obst_cfg;
                c.lx = vel(heading.x, lin_spd);
                c.ly = vel(heading.y, lin_spd);
                c.lz = vel(heading.z, lin_spd);
                c.az = vel(heading.yaw, turn_spd);
                // front wins over the side pairs, right pair over left pair
                if (near[latg_pkg::SEC_FRONT])
                begin
                    c.lx  = '0;
                    c.ly  = '0;
                    c.az  = '0;
                    c.act = latg_pkg::ACT_STOP;
                end
                else if (near[latg_pkg::SEC_FRONT_RIGHT] && near[latg_pkg::SEC_RIGHT])
                begin
                    c.az  = vel(latg_pkg::D_POS, turn_spd);
                    c.act = latg_pkg::ACT_LEFT;
                end
                else if (near[latg_pkg::SEC_FRONT_LEFT] && near[latg_pkg::SEC_LEFT])
                begin
                    c.az  = vel(latg_pkg::D_NEG, turn_spd);
                    c.act = latg_pkg::ACT_RIGHT;
                end
                pending_cmds.push_back(c);
            end
        end
    endtask

    task automatic push_key(input logic [7:0] k);
        input_beat_t b;
        b.req = latg_pkg::REQ_KEY;
        b.key = k;
        b.rng = RNG_W'($urandom);
        input_beats.push_back(b);
    endtask

    // random key events, with long runs of one speed key to reach saturation
    task automatic queue_keys(input int n);
        int         pick;
        logic [7:0] k;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                k = known_keys[$urandom_range(SPEED_KEY_BASE, known_keys.len() - 1)];
                repeat ($urandom_range(10, 90))
                    push_key(k);
            end
            else if (pick < 9)
                push_key(latg_pkg::KEY_CTRL_C);
            else if (pick < 25)
                push_key(8'($urandom_range(0, 255)));
            else
                push_key(known_keys[$urandom_range(0, known_keys.len() - 1)]);
        end
    endtask

    // range value for one sample; near sectors now and then dip below the threshold
    function automatic logic [RNG_W-1:0] pick_range(input bit near);
        if (near && obst_cfg != 0 && $urandom_range(0, 39) == 0)
            return RNG_W'($urandom_range(0, obst_cfg - 1));
        if ($urandom_range(0, 59) == 0)
            return obst_cfg;
        return RNG_W'($urandom_range(obst_cfg, 16'hFFFF));
    endfunction

    // range samples in scan order, the odd key event slipped in mid-scan
    task automatic queue_samples(input int n);
        input_beat_t b;
        logic [31:0] rnd;
        for (int i = 0; i < n; i++)
        begin
            if (gen_pos == 0)
            begin
                // stop, turn left, turn right, both pairs, clear, or any mix
                near_mask = '0;
                rnd       = $urandom;
                case ($urandom_range(0, 5))
                    0: near_mask[latg_pkg::SEC_FRONT] = 1'b1;
                    1:
                    begin
                        near_mask[latg_pkg::SEC_RIGHT]       = 1'b1;
                        near_mask[latg_pkg::SEC_FRONT_RIGHT] = 1'b1;
                    end
                    2:
                    begin
                        near_mask[latg_pkg::SEC_LEFT]       = 1'b1;
                        near_mask[latg_pkg::SEC_FRONT_LEFT] = 1'b1;
                    end
                    3:
                    begin
                        near_mask                     = '1;
                        near_mask[latg_pkg::SEC_FRONT] = 1'b0;
                    end
                    4: ;
                    default: near_mask = rnd[latg_pkg::SECTORS-1:0];
                endcase
            end
            b.req = latg_pkg::REQ_RANGE;
            b.key = 8'($urandom);
            b.rng = pick_range(near_mask[gen_pos * latg_pkg::SECTORS / SCAN_LEN]);
            input_beats.push_back(b);
            gen_pos = (gen_pos + 1 == SCAN_LEN) ? 0 : gen_pos + 1;
            if ($urandom_range(0, 149) == 0)
                queue_keys(1);
        end
    endtask

    // block idle: everything sent, nothing owed, plus pipeline latency
    task automatic wait_drained;
        while (input_beats.size() != 0 || in_valid || pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [latg_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == latg_pkg::CFG_OBSTACLE)
            obst_cfg = val;
        else
            far_cfg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input side: sample the handshake at the rising edge and predict
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            guard_step(req_type, key_code, range_mm);
    end

    // input side: present the next beat at the falling edge, with idle bursts
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (idle_on && !tail_quiet && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 8);
                in_valid <= 1'b0;
            end
            else if (input_beats.size() != 0)
            begin
                next_beat = input_beats.pop_front();
                in_valid <= 1'b1;
                req_type <= next_beat.req;
                key_code <= next_beat.key;
                range_mm <= next_beat.rng;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side: stall bursts at the falling edge
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && !tail_quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result side: check every accepted beat against the oldest owed command
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_cmd = '{lin_x, lin_y, lin_z, ang_z,
                        latg_pkg::action_t'(avoid_action), mode_exit};
            if (pending_cmds.size() == 0)
            begin
                if (faults < 10)
                    $display("unexpected command: %0d %0d %0d %0d act %0d exit %0d",
                             $signed(got_cmd.lx), $signed(got_cmd.ly), $signed(got_cmd.lz),
                             $signed(got_cmd.az), got_cmd.act, got_cmd.ex);
                faults++;
            end
            else
            begin
                want_cmd = pending_cmds.pop_front();
                if (got_cmd != want_cmd)
                begin
                    if (faults < 10)
                        $display({"command mismatch: want %0d %0d %0d %0d act %0d exit %0d,",
                                  " got %0d %0d %0d %0d act %0d exit %0d"},
                                 $signed(want_cmd.lx), $signed(want_cmd.ly),
                                 $signed(want_cmd.lz), $signed(want_cmd.az),
                                 want_cmd.act, want_cmd.ex,
                                 $signed(got_cmd.lx), $signed(got_cmd.ly),
                                 $signed(got_cmd.lz), $signed(got_cmd.az),
                                 got_cmd.act, got_cmd.ex);
                    faults++;
                end
            end
        end
    end

    // cycle limit, and busy / calm stretches for both idling sides
    always @(posedge clk)
    begin
        cycles++;
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(50, 300);
            idle_on = !idle_on;
        end
        else
            stretch_left--;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // stimulus: opening keys, a saturating speed run, then one scan under a new threshold
    initial
    begin : stimulus
        string                      opening;
        logic [latg_pkg::CFG_W-1:0] obst_val;
        opening = "ijou,OJtbKqzwxeca";

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        // every key group once, unknown codes at both ends, ctrl-c then a move
        for (int i = 0; i < opening.len(); i++)
            push_key(opening[i]);
        push_key(8'h00);
        push_key(8'hFF);
        push_key(latg_pkg::KEY_CTRL_C);
        push_key("m");
        // drive both speeds into saturation
        repeat (70)
            push_key("q");
        wait_drained();

        obst_val = latg_pkg::CFG_W'($urandom_range(500, 4000));
        write_reg(latg_pkg::CFG_OBSTACLE, obst_val);
        write_reg(latg_pkg::CFG_FAR_START,
                  latg_pkg::CFG_W'($urandom_range(obst_val, 16'hFFFF)));
        queue_keys(10);
        queue_samples(SCAN_LEN - 150);
        wait_drained();

        // no idling for the rest of the scan
        tail_quiet = 1'b1;
        queue_samples(150);
        queue_keys(10);
        wait_drained();

        repeat (10)
            @(posedge clk);
        if (faults == 0 && pending_cmds.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/latg_pkg.sv
rtl/latg_key.sv
rtl/latg_scan.sv
rtl/lidar_assisted_teleop_guard.sv
bench/testbench.sv
